// ===== hdl/sft_pkg.sv =====
// Shared types and constants of the sprite frame transform block.
package sft_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int COORD_W    = 7;
    localparam int SIZE_W     = 7;
    localparam int PIX_W      = 8;
    localparam int OP_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(16);
    localparam logic [PIX_W-1:0]  EXCLUDE_RST      = '0;
    localparam logic [PIX_W-1:0]  INVERT_BASE      = PIX_W'(31);

    typedef enum logic [OP_W-1:0] {
        OP_IDENTITY   = 4'd0,
        OP_FLIP_H     = 4'd1,
        OP_FLIP_V     = 4'd2,
        OP_SHIFT_UP   = 4'd3,
        OP_SHIFT_DOWN = 4'd4,
        OP_SHIFT_LEFT = 4'd5,
        OP_SHIFT_RGHT = 4'd6,
        OP_ROT90      = 4'd7,
        OP_ENLARGE    = 4'd8,
        OP_SHRINK     = 4'd9,
        OP_SPREAD_H   = 4'd10,
        OP_SPREAD_V   = 4'd11,
        OP_INVERT     = 4'd12,
        OP_RAINBOW    = 4'd13,
        OP_RAINBOW_EX = 4'd14
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_OPERATION     = 2'd2,
        CFG_EXCLUDE_COLOR = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic is_read;
        logic reject;
    } cmd_ctl_t;

endpackage

// ===== hdl/sft_if.sv =====
// Handshake channels of the sprite frame transform block.
interface sft_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [sft_pkg::COORD_W-1:0]  pos_x;
    logic [sft_pkg::COORD_W-1:0]  pos_y;
    logic [sft_pkg::PIX_W-1:0]    write_pixel;

    modport source (output valid, req_type, pos_x, pos_y, write_pixel, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, write_pixel, output ready);
endinterface

interface sft_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [sft_pkg::PIX_W-1:0]  read_pixel;
    logic                       status;

    modport source (output valid, read_pixel, status, input ready);
    modport sink (input valid, read_pixel, status, output ready);
endinterface

interface sft_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sft_pkg::CFG_IDX_W-1:0]   index;
    logic [sft_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/sft_front.sv =====
// Front end: bounds check and coordinate mapping of incoming items.
module sft_front #(
    parameter int MAX_WIDTH  = sft_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sft_pkg::MAX_HEIGHT_DEF,
    parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic [sft_pkg::SIZE_W-1:0]  frame_width,
    input  logic [sft_pkg::SIZE_W-1:0]  frame_height,
    input  logic [sft_pkg::OP_W-1:0]    operation,
    sft_req_if.sink                     req,
    input  logic                        q_full,
    output logic                        push,
    output sft_pkg::cmd_ctl_t           ctl,
    output logic [ADDR_W-1:0]           addr,
    output logic [sft_pkg::PIX_W-1:0]   wdata
);

    localparam int SW = sft_pkg::SIZE_W;

    logic [SW-1:0] w;
    logic [SW-1:0] h;
    logic [SW-1:0] x;
    logic [SW-1:0] y;
    logic [SW-1:0] sx;
    logic [SW-1:0] sy;
    logic [SW:0]   ow;
    logic [SW:0]   oh;

    assign x = req.pos_x;
    assign y = req.pos_y;

    always_comb
    begin
        if (frame_width == '0)
            w = SW'(1);
        else if (int'(frame_width) > MAX_WIDTH)
            w = SW'(MAX_WIDTH);
        else
            w = frame_width;
        if (frame_height == '0)
            h = SW'(1);
        else if (int'(frame_height) > MAX_HEIGHT)
            h = SW'(MAX_HEIGHT);
        else
            h = frame_height;
    end

    always_comb
    begin
        ow = {1'b0, w};
        oh = {1'b0, h};
        case (sft_pkg::op_t'(operation))
            sft_pkg::OP_ENLARGE:
            begin
                ow = {w, 1'b0};
                oh = {h, 1'b0};
            end
            sft_pkg::OP_SHRINK:
            begin
                ow = {2'b00, w[SW-1:1]};
                oh = {2'b00, h[SW-1:1]};
            end
            sft_pkg::OP_SPREAD_H: ow = {w, 1'b0};
            sft_pkg::OP_SPREAD_V: oh = {h, 1'b0};
            default: ;
        endcase
    end

    always_comb
    begin
        sx = x;
        sy = y;
        if (req.req_type)
        begin
            case (sft_pkg::op_t'(operation))
                sft_pkg::OP_FLIP_H:     sx = w - SW'(1) - x;
                sft_pkg::OP_FLIP_V:     sy = h - SW'(1) - y;
                sft_pkg::OP_SHIFT_UP:   sy = (y + SW'(1) == h) ? '0 : y + SW'(1);
                sft_pkg::OP_SHIFT_DOWN: sy = (y == '0) ? h - SW'(1) : y - SW'(1);
                sft_pkg::OP_SHIFT_LEFT: sx = (x + SW'(1) == w) ? '0 : x + SW'(1);
                sft_pkg::OP_SHIFT_RGHT: sx = (x == '0) ? w - SW'(1) : x - SW'(1);
                sft_pkg::OP_ROT90:
                begin
                    if (w == h)
                    begin
                        sx = y;
                        sy = w - SW'(1) - x;
                    end
                end
                sft_pkg::OP_ENLARGE:
                begin
                    sx = {1'b0, x[SW-1:1]};
                    sy = {1'b0, y[SW-1:1]};
                end
                sft_pkg::OP_SHRINK:
                begin
                    sx = {x[SW-2:0], 1'b0};
                    sy = {y[SW-2:0], 1'b0};
                end
                sft_pkg::OP_SPREAD_H: if (x >= w) sx = x - w;
                sft_pkg::OP_SPREAD_V: if (y >= h) sy = y - h;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ctl.is_read = req.req_type;
        if (req.req_type)
            ctl.reject = ({1'b0, x} >= ow) || ({1'b0, y} >= oh);
        else
            ctl.reject = (x >= w) || (y >= h);
    end

    assign addr      = ADDR_W'(sy) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sx);
    assign wdata     = req.write_pixel;
    assign req.ready = !q_full;
    assign push      = req.valid && !q_full;

endmodule

// ===== hdl/sft_queue.sv =====
// Small command queue between the front end and the frame store.
module sft_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = sft_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [DATA_W-1:0]            wr_data,
    output logic                         full,
    input  logic                         pop,
    output logic                         rd_valid,
    output logic [DATA_W-1:0]            rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [LW-1:0]     level_reg;
    logic [LW-1:0]     level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            level_next = level_reg + LW'(1);
        else if (pop && !push)
            level_next = level_reg - LW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    assign full     = (level_reg == LW'(DEPTH));
    assign rd_valid = (level_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign level    = level_reg;

endmodule

// ===== hdl/sft_back.sv =====
// Back end: frame store access, colour map and result register.
module sft_back #(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  sft_pkg::cmd_ctl_t           q_ctl,
    input  logic [ADDR_W-1:0]           q_addr,
    input  logic [sft_pkg::PIX_W-1:0]   q_wdata,
    output logic                        pop,
    input  logic [sft_pkg::OP_W-1:0]    operation,
    input  logic [sft_pkg::PIX_W-1:0]   exclude_color,
    sft_rsp_if.source                   rsp
);

    localparam int PW = sft_pkg::PIX_W;

    logic [PW-1:0]      mem [DEPTH];
    logic [PW-1:0]      rd_data_reg;
    logic               s1_vld_reg;
    logic               s1_vld_next;
    sft_pkg::cmd_ctl_t  s1_ctl_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [PW-1:0]      pixel_reg;
    logic               status_reg;
    logic               out_adv;
    logic [PW-1:0]      mapped;

    assign out_adv = !out_vld_reg || rsp.ready;
    assign pop     = q_valid && (!s1_vld_reg || out_adv);

    always_comb
    begin
        mapped = rd_data_reg;
        case (sft_pkg::op_t'(operation))
            sft_pkg::OP_INVERT:
                mapped = sft_pkg::INVERT_BASE - rd_data_reg;
            sft_pkg::OP_RAINBOW:
                if (rd_data_reg != '0)
                    mapped = rd_data_reg + PW'(1);
            sft_pkg::OP_RAINBOW_EX:
                if (rd_data_reg != '0 && rd_data_reg != exclude_color)
                    mapped = rd_data_reg + PW'(1);
            default: ;
        endcase
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (pop)
            s1_vld_next = 1'b1;
        else if (out_adv)
            s1_vld_next = 1'b0;
        out_vld_next = out_adv ? s1_vld_reg : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !q_ctl.reject)
        begin
            if (q_ctl.is_read)
                rd_data_reg <= mem[q_addr];
            else
                mem[q_addr] <= q_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            s1_ctl_reg <= q_ctl;
        if (out_adv && s1_vld_reg)
        begin
            status_reg <= s1_ctl_reg.reject;
            pixel_reg  <= (s1_ctl_reg.is_read && !s1_ctl_reg.reject) ? mapped : '0;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.read_pixel = pixel_reg;
    assign rsp.status     = status_reg;

endmodule

// ===== hdl/sprite_frame_transform_core.sv =====
// Top level of the sprite frame transform block.
// Holds one paletted frame and returns its pixels under a chosen operation.
// Channels: req takes items (write a source pixel or read a mapped pixel),
// rsp returns exactly one item per request (read_pixel and status), cfg
// writes the four registers (width, height, operation, exclude colour).
// cfg is always ready; write it only while no item is in flight.
// Path of an item: front mapping into the queue, one frame store access,
// then the result register.
// Throughput: one item per cycle while rsp is not stalled, set by the
// single-port frame store that takes one access per cycle.
// A two-entry queue parts the front end from the store; when rsp stalls,
// the store stage and the queue fill and req.ready falls when the queue is
// full. Reset empties the queue and pipeline and sets the registers to
// 16 by 16, identity, exclude colour zero. Frame contents are undefined
// until written.
module sprite_frame_transform_core #(
    parameter int MAX_WIDTH  = sft_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sft_pkg::MAX_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sft_cfg_if.sink    cfg,
    sft_req_if.sink    req,
    sft_rsp_if.source  rsp
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CW     = $bits(sft_pkg::cmd_ctl_t);
    localparam int PW     = sft_pkg::PIX_W;
    localparam int QW     = CW + PW + ADDR_W;
    localparam int QD     = sft_pkg::QUEUE_DEPTH;
    localparam int LW     = $clog2(QD + 1);

    logic [sft_pkg::SIZE_W-1:0] width_reg;
    logic [sft_pkg::SIZE_W-1:0] height_reg;
    logic [sft_pkg::OP_W-1:0]   op_reg;
    logic [PW-1:0]              exclude_reg;

    logic               f_push;
    sft_pkg::cmd_ctl_t  f_ctl;
    logic [ADDR_W-1:0]  f_addr;
    logic [PW-1:0]      f_wdata;
    logic               q_full;
    logic               q_valid;
    logic               q_pop;
    logic [QW-1:0]      q_data;
    logic [LW-1:0]      q_level;
    sft_pkg::cmd_ctl_t  q_ctl;
    logic [ADDR_W-1:0]  q_addr;
    logic [PW-1:0]      q_wdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= sft_pkg::FRAME_WIDTH_RST;
            height_reg  <= sft_pkg::FRAME_HEIGHT_RST;
            op_reg      <= sft_pkg::OP_IDENTITY;
            exclude_reg <= sft_pkg::EXCLUDE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (sft_pkg::cfg_idx_t'(cfg.index))
                sft_pkg::CFG_FRAME_WIDTH:   width_reg   <= cfg.data[sft_pkg::SIZE_W-1:0];
                sft_pkg::CFG_FRAME_HEIGHT:  height_reg  <= cfg.data[sft_pkg::SIZE_W-1:0];
                sft_pkg::CFG_OPERATION:     op_reg      <= cfg.data[sft_pkg::OP_W-1:0];
                sft_pkg::CFG_EXCLUDE_COLOR: exclude_reg <= cfg.data[PW-1:0];
                default: ;
            endcase
        end
    end

    sft_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .operation    (op_reg),
        .req          (req),
        .q_full       (q_full),
        .push         (f_push),
        .ctl          (f_ctl),
        .addr         (f_addr),
        .wdata        (f_wdata)
    );

    sft_queue #(
        .DATA_W (QW),
        .DEPTH  (QD)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .wr_data  ({f_ctl, f_wdata, f_addr}),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data),
        .level    (q_level)
    );

    assign q_ctl   = sft_pkg::cmd_ctl_t'(q_data[QW-1 -: CW]);
    assign q_wdata = q_data[ADDR_W +: PW];
    assign q_addr  = q_data[ADDR_W-1:0];

    sft_back #(
        .ADDR_W (ADDR_W),
        .DEPTH  (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ctl         (q_ctl),
        .q_addr        (q_addr),
        .q_wdata       (q_wdata),
        .pop           (q_pop),
        .operation     (op_reg),
        .exclude_color (exclude_reg),
        .rsp           (rsp)
    );

`ifndef NO_ASSERTIONS
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> rsp.read_pixel == '0)
        else $error("rejected item returned a nonzero pixel");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= LW'(QD))
        else $error("command queue level above its depth");

    a_queue_grow: assert property (@(posedge clk) disable iff (!rst_n)
        f_push && !q_pop |=> q_level == $past(q_level) + LW'(1))
        else $error("command queue lost an item");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("back end popped an empty queue");
`endif

endmodule

// ===== bench/sft_pixel_checker.sv =====
// Pixel checker: mirrors the frame store and registers, predicts each result and compares.
`timescale 1ns / 100ps

module sft_pixel_checker (
    input  logic clk,
    input  logic rst_n,
    sft_cfg_if   cfg,
    sft_req_if   req,
    sft_rsp_if   rsp,
    output int   error_count,
    output int   outstanding
);
    import sft_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] read_pixel;
        logic             status;
    } pixel_result_t;

    logic [PIX_W-1:0]  frame_copy [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [OP_W-1:0]   op_reg;
    logic [PIX_W-1:0]  exclude_reg;
    pixel_result_t     pending_results [$];
    int                mismatches = 0;
    int                queued = 0;

    assign error_count = mismatches;
    assign outstanding = queued;

    function automatic int clamp_dim(logic [SIZE_W-1:0] v, int lim);
        if (v == '0)
            return 1;
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    function automatic pixel_result_t map_pixel(logic is_read, logic [COORD_W-1:0] px,
                                                logic [COORD_W-1:0] py,
                                                logic [PIX_W-1:0] wpix);
        int               w;
        int               h;
        int               x;
        int               y;
        int               ow;
        int               oh;
        int               sx;
        int               sy;
        logic [PIX_W-1:0] v;
        pixel_result_t    res;
        w   = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h   = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        x   = int'(px);
        y   = int'(py);
        ow  = w;
        oh  = h;
        sx  = x;
        sy  = y;
        res = '0;
        if (!is_read)
        begin
            if (x >= w || y >= h)
                res.status = 1'b1;
            else
                frame_copy[y * MAX_WIDTH_DEF + x] = wpix;
            return res;
        end
        case (op_reg)
            OP_ENLARGE:
            begin
                ow = 2 * w;
                oh = 2 * h;
            end
            OP_SHRINK:
            begin
                ow = w / 2;
                oh = h / 2;
            end
            OP_SPREAD_H: ow = 2 * w;
            OP_SPREAD_V: oh = 2 * h;
            default: ;
        endcase
        if (x >= ow || y >= oh)
        begin
            res.status = 1'b1;
            return res;
        end
        case (op_reg)
            OP_FLIP_H:     sx = w - 1 - x;
            OP_FLIP_V:     sy = h - 1 - y;
            OP_SHIFT_UP:   sy = (y + 1 == h) ? 0 : y + 1;
            OP_SHIFT_DOWN: sy = (y == 0) ? h - 1 : y - 1;
            OP_SHIFT_LEFT: sx = (x + 1 == w) ? 0 : x + 1;
            OP_SHIFT_RGHT: sx = (x == 0) ? w - 1 : x - 1;
            OP_ROT90:
            begin
                if (w == h)
                begin
                    sx = y;
                    sy = w - 1 - x;
                end
            end
            OP_ENLARGE:
            begin
                sx = x / 2;
                sy = y / 2;
            end
            OP_SHRINK:
            begin
                sx = 2 * x;
                sy = 2 * y;
            end
            OP_SPREAD_H: if (x >= w) sx = x - w;
            OP_SPREAD_V: if (y >= h) sy = y - h;
            default: ;
        endcase
        if (sx < MAX_WIDTH_DEF && sy < MAX_HEIGHT_DEF)
            v = frame_copy[sy * MAX_WIDTH_DEF + sx];
        else
            v = '0;
        case (op_reg)
            OP_INVERT:     v = INVERT_BASE - v;
            OP_RAINBOW:    if (v != '0) v = v + 1'b1;
            OP_RAINBOW_EX: if (v != '0 && v != exclude_reg) v = v + 1'b1;
            default: ;
        endcase
        res.read_pixel = v;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t got;
        pixel_result_t want;
        if (!rst_n)
        begin
            width_reg   = FRAME_WIDTH_RST;
            height_reg  = FRAME_HEIGHT_RST;
            op_reg      = OP_IDENTITY;
            exclude_reg = EXCLUDE_RST;
            pending_results.delete();
            queued <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.read_pixel = rsp.read_pixel;
                got.status     = rsp.status;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected item: read_pixel %0d status %0d",
                             $time, got.read_pixel, got.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.read_pixel !== want.read_pixel)
                    begin
                        mismatches++;
                        $display("%0t: read_pixel expected %0d actual %0d",
                                 $time, want.read_pixel, got.read_pixel);
                    end
                    if (got.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
            if (req.valid && req.ready)
                pending_results.push_back(map_pixel(req.req_type, req.pos_x, req.pos_y,
                                                    req.write_pixel));
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_FRAME_WIDTH:   width_reg   = cfg.data[SIZE_W-1:0];
                    CFG_FRAME_HEIGHT:  height_reg  = cfg.data[SIZE_W-1:0];
                    CFG_OPERATION:     op_reg      = cfg.data[OP_W-1:0];
                    CFG_EXCLUDE_COLOR: exclude_reg = cfg.data[PIX_W-1:0];
                    default: ;
                endcase
            end
            queued <= pending_results.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives pixel items and register writes into the transform core.
`timescale 1ns / 100ps

module testbench;
    import sft_pkg::*;

    localparam logic REQ_WRITE      = 1'b0;
    localparam logic REQ_READ       = 1'b1;
    localparam int   CYCLE_LIMIT    = 1_000_000;
    localparam int   RANDOM_PHASES  = 20;
    localparam int   PHASE_ITEMS    = 50;
    localparam int   PRESSURE_PHASE = 8;
    localparam int   HOLD_CYCLES    = 200;
    localparam int   DRAIN_CYCLES   = 8;
    localparam int   AREA_CAP       = 256;
    localparam int   COORD_MAX      = (1 << COORD_W) - 1;
    localparam int   OP_CODE_MAX    = (1 << OP_W) - 1;

    logic clk;
    logic rst_n;

    sft_cfg_if cfg_bus ();
    sft_req_if req_bus ();
    sft_rsp_if rsp_bus ();

    int               error_count;
    int               outstanding;
    int               cycle_count = 0;
    bit               written_map [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
    int               frame_w;
    int               frame_h;
    int               out_w;
    int               out_h;
    logic [OP_W-1:0]  cur_op;
    logic [PIX_W-1:0] cur_exclude;
    bit               burst_mode;
    bit               hold_off;

    sprite_frame_transform_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    sft_pixel_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_bus),
        .req         (req_bus),
        .rsp         (rsp_bus),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int eff_dim(logic [CFG_DATA_W-1:0] d, int lim);
        int v;
        v = int'(d[SIZE_W-1:0]);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return cur_exclude;
        if (r < 30)
            return '0;
        if (r < 40)
            return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int                    r;
        logic [CFG_DATA_W-1:0] d;
        r = $urandom_range(0, 99);
        if (r < 65)
            d = CFG_DATA_W'($urandom_range(1, 8));
        else if (r < 73)
            d = '0;
        else if (r < 81)
            d = CFG_DATA_W'(MAX_WIDTH_DEF);
        else if (r < 89)
            d = CFG_DATA_W'($urandom_range(MAX_WIDTH_DEF + 1, COORD_MAX));
        else
            d = CFG_DATA_W'($urandom_range(9, MAX_WIDTH_DEF - 1));
        d[CFG_DATA_W-1] = ($urandom_range(0, 3) == 0);
        return d;
    endfunction

    task automatic send_item(logic kind, int x, int y, logic [PIX_W-1:0] pix);
        int gap;
        gap = burst_mode ? 0 : idle_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= kind;
        req_bus.pos_x       <= COORD_W'(x);
        req_bus.pos_y       <= COORD_W'(y);
        req_bus.write_pixel <= pix;
        do @(posedge clk); while (!req_bus.ready);
        if (kind == REQ_WRITE && x < frame_w && y < frame_h)
            written_map[y * MAX_WIDTH_DEF + x] = 1'b1;
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= d;
        do @(posedge clk); while (!cfg_bus.ready);
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pace_cycles(int n);
        for (int i = 0; i < n && !hold_off; i++)
            @(posedge clk);
    endtask

    task automatic apply_setup(logic [CFG_DATA_W-1:0] w_d, logic [CFG_DATA_W-1:0] h_d,
                               logic [CFG_DATA_W-1:0] op_d, logic [CFG_DATA_W-1:0] ex_d);
        drain();
        cfg_write(CFG_FRAME_WIDTH, w_d);
        cfg_write(CFG_FRAME_HEIGHT, h_d);
        cfg_write(CFG_OPERATION, op_d);
        cfg_write(CFG_EXCLUDE_COLOR, ex_d);
        cfg_bus.valid <= 1'b0;
        frame_w     = eff_dim(w_d, MAX_WIDTH_DEF);
        frame_h     = eff_dim(h_d, MAX_HEIGHT_DEF);
        cur_op      = op_d[OP_W-1:0];
        cur_exclude = ex_d;
        out_w       = frame_w;
        out_h       = frame_h;
        case (cur_op)
            OP_ENLARGE:
            begin
                out_w = 2 * frame_w;
                out_h = 2 * frame_h;
            end
            OP_SHRINK:
            begin
                out_w = frame_w / 2;
                out_h = frame_h / 2;
            end
            OP_SPREAD_H: out_w = 2 * frame_w;
            OP_SPREAD_V: out_h = 2 * frame_h;
            default: ;
        endcase
    endtask

    task automatic fill_frame();
        for (int y = 0; y < frame_h; y++)
            for (int x = 0; x < frame_w; x++)
                if (!written_map[y * MAX_WIDTH_DEF + x])
                    send_item(REQ_WRITE, x, y, pick_pixel());
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68 && out_w > 0 && out_h > 0)
            send_item(REQ_READ, $urandom_range(0, out_w - 1), $urandom_range(0, out_h - 1),
                      pick_pixel());
        else if (r < 78)
            send_item(REQ_READ, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      pick_pixel());
        else if (r < 94)
            send_item(REQ_WRITE, $urandom_range(0, frame_w - 1),
                      $urandom_range(0, frame_h - 1), pick_pixel());
        else
            send_item(REQ_WRITE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      pick_pixel());
    endtask

    initial
    begin : rsp_pacing
        int stall;
        rsp_bus.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                pace_cycles($urandom_range(50, 150));
            else
                pace_cycles($urandom_range(1, 12));
            stall = idle_gap();
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                pace_cycles(stall);
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] w_d;
        logic [CFG_DATA_W-1:0] h_d;
        logic [CFG_DATA_W-1:0] op_d;
        logic [CFG_DATA_W-1:0] ex_d;
        rst_n               = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_FRAME_WIDTH;
        cfg_bus.data        = '0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_WRITE;
        req_bus.pos_x       = '0;
        req_bus.pos_y       = '0;
        req_bus.write_pixel = '0;
        burst_mode          = 1'b0;
        hold_off            = 1'b0;
        frame_w             = int'(FRAME_WIDTH_RST);
        frame_h             = int'(FRAME_HEIGHT_RST);
        out_w               = frame_w;
        out_h               = frame_h;
        cur_op              = OP_IDENTITY;
        cur_exclude         = EXCLUDE_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        apply_setup(CFG_DATA_W'(4), CFG_DATA_W'(4), CFG_DATA_W'(OP_IDENTITY), 8'd7);
        fill_frame();
        send_item(REQ_WRITE, 0, 0, 8'h00);
        send_item(REQ_WRITE, 3, 0, 8'hFF);
        send_item(REQ_WRITE, 0, 3, 8'd7);
        send_item(REQ_WRITE, 3, 3, 8'h80);
        send_item(REQ_WRITE, COORD_MAX, 0, 8'h55);
        send_item(REQ_WRITE, 0, COORD_MAX, 8'hAA);
        send_item(REQ_WRITE, 4, 3, 8'h11);
        send_item(REQ_READ, COORD_MAX, COORD_MAX, 8'hFF);
        send_item(REQ_READ, 3, 4, 8'h00);
        send_item(REQ_READ, 3, 3, 8'h00);
        for (int op = OP_FLIP_H; op <= OP_CODE_MAX; op++)
        begin
            apply_setup(CFG_DATA_W'(4), CFG_DATA_W'(4), CFG_DATA_W'(op), 8'd7);
            send_item(REQ_READ, op % 4, op / 4, 8'h00);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            w_d = pick_size();
            h_d = pick_size();
            if (eff_dim(w_d, MAX_WIDTH_DEF) * eff_dim(h_d, MAX_HEIGHT_DEF) > AREA_CAP)
                h_d = CFG_DATA_W'($urandom_range(1, 4));
            if ($urandom_range(0, 3) == 0 && eff_dim(w_d, MAX_WIDTH_DEF) <= 16)
                h_d = w_d;
            op_d = CFG_DATA_W'($urandom_range(0, 255));
            ex_d = CFG_DATA_W'($urandom_range(0, 255));
            case (p)
                0: w_d = '0;
                1:
                begin
                    w_d = '1;
                    h_d = CFG_DATA_W'(2);
                end
                2:
                begin
                    w_d  = CFG_DATA_W'(3);
                    h_d  = CFG_DATA_W'(5);
                    op_d = CFG_DATA_W'(OP_ROT90);
                end
                3:
                begin
                    w_d  = CFG_DATA_W'(1);
                    h_d  = CFG_DATA_W'(4);
                    op_d = CFG_DATA_W'(OP_SHRINK);
                end
                4: op_d = '1;
                5:
                begin
                    w_d  = CFG_DATA_W'(5);
                    h_d  = CFG_DATA_W'(5);
                    op_d = CFG_DATA_W'(OP_ROT90);
                end
                6:
                begin
                    w_d  = CFG_DATA_W'(2);
                    h_d  = CFG_DATA_W'(MAX_HEIGHT_DEF);
                    op_d = CFG_DATA_W'(OP_ENLARGE);
                end
                default: ;
            endcase
            apply_setup(w_d, h_d, op_d, ex_d);
            fill_frame();
            if (p == PRESSURE_PHASE)
            begin
                burst_mode = 1'b1;
                hold_off   = 1'b1;
            end
            repeat (PHASE_ITEMS) random_item();
            burst_mode = 1'b0;
        end

        drain();
        if (error_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
